// ===== design/slwg_pkg.sv =====
// Package for the slip-wall ghost-state pipeline.
// Holds word types, the divider stage bundle and pipeline depth constants.
// No dependencies.
package slwg_pkg;

    localparam int LANES        = 3;
    localparam int FRONT_STAGES = 4;
    localparam int DIV_STEPS    = 33;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [31:0] energy;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] ghost_density;
        logic signed [31:0] ghost_mom_x;
        logic signed [31:0] ghost_mom_y;
        logic signed [31:0] ghost_mom_z;
        logic signed [31:0] ghost_energy;
        logic               invalid;
    } out_t;

    // One divider stage: shared divisor, per-lane partial remainder and a
    // register that shifts numerator bits out and quotient bits in.
    typedef struct packed {
        logic [63:0]                  nn;
        logic [LANES-1:0][63:0]       rem;
        logic [LANES-1:0][DIV_STEPS-1:0] nq;
        logic [LANES-1:0][31:0]       mom;
        logic [LANES-1:0]             qneg;
        logic [31:0]                  density;
        logic [31:0]                  energy;
        logic                         invalid;
    } div_t;

endpackage

// ===== design/slwg_front.sv =====
// Front end of the slip-wall pipeline: products, dot product, |n|^2 and
// the scaled numerators, in four register stages. Uses slwg_pkg.
module slwg_front (
    input  logic         clk,
    input  logic         en,
    input  slwg_pkg::in_t in_data,
    output slwg_pkg::div_t div_out
);

    localparam int L = slwg_pkg::LANES;

    logic signed [31:0] m_in [L];
    logic signed [31:0] n_in [L];

    // Stage 1.
    logic signed [63:0] p_reg [L];
    logic signed [63:0] s_reg [L];
    logic signed [31:0] m1_reg [L];
    logic signed [31:0] n1_reg [L];
    logic [31:0]        den1_reg;
    logic [31:0]        egy1_reg;

    // Stage 2.
    logic signed [65:0] dot;
    logic [65:0]        nn_sum;
    logic [65:0]        dot_abs;
    logic [63:0]        dmag2_reg;
    logic [63:0]        nn2_reg;
    logic [31:0]        absn2_reg [L];
    logic [L-1:0]       qneg2_reg;
    logic [31:0]        m2_reg [L];
    logic [31:0]        den2_reg;
    logic [31:0]        egy2_reg;
    logic               inv2_reg;

    // Stage 3.
    logic [63:0]        pl3_reg [L];
    logic [63:0]        ph3_reg [L];
    logic [63:0]        nn3_reg;
    logic [L-1:0]       qneg3_reg;
    logic [31:0]        m3_reg [L];
    logic [31:0]        den3_reg;
    logic [31:0]        egy3_reg;
    logic               inv3_reg;

    // Stage 4.
    logic [95:0]        half_num [L];
    slwg_pkg::div_t     div_next;
    slwg_pkg::div_t     div_reg;

    always_comb
    begin
        m_in[0] = in_data.mom_x;
        m_in[1] = in_data.mom_y;
        m_in[2] = in_data.mom_z;
        n_in[0] = in_data.normal_x;
        n_in[1] = in_data.normal_y;
        n_in[2] = in_data.normal_z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < L; i++)
            begin
                p_reg[i]  <= 64'(m_in[i]) * 64'(n_in[i]);
                s_reg[i]  <= 64'(n_in[i]) * 64'(n_in[i]);
                m1_reg[i] <= m_in[i];
                n1_reg[i] <= n_in[i];
            end
            den1_reg <= in_data.density;
            egy1_reg <= in_data.energy;
        end
    end

    always_comb
    begin
        dot    = 66'(p_reg[0]) + 66'(p_reg[1]) + 66'(p_reg[2]);
        nn_sum = {2'b00, s_reg[0]} + {2'b00, s_reg[1]} + {2'b00, s_reg[2]};
        dot_abs = dot[65] ? 66'(-dot) : 66'(dot);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag2_reg <= dot_abs[63:0];
            nn2_reg   <= nn_sum[63:0];
            for (int i = 0; i < L; i++)
            begin
                absn2_reg[i] <= n1_reg[i][31] ? 32'(-n1_reg[i]) : 32'(n1_reg[i]);
                qneg2_reg[i] <= dot[65] ^ n1_reg[i][31];
                m2_reg[i]    <= m1_reg[i];
            end
            den2_reg <= den1_reg;
            egy2_reg <= egy1_reg;
            inv2_reg <= (nn_sum == 66'd0) || den1_reg[31] || (den1_reg == 32'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < L; i++)
            begin
                pl3_reg[i] <= 64'(dmag2_reg[31:0]) * 64'(absn2_reg[i]);
                ph3_reg[i] <= 64'(dmag2_reg[63:32]) * 64'(absn2_reg[i]);
                m3_reg[i]  <= m2_reg[i];
            end
            nn3_reg   <= nn2_reg;
            qneg3_reg <= qneg2_reg;
            den3_reg  <= den2_reg;
            egy3_reg  <= egy2_reg;
            inv3_reg  <= inv2_reg;
        end
    end

    // The numerator is 2*dmag*|n_i|; its top bits start the remainder and
    // the low bits are shifted in one per divider step.
    always_comb
    begin
        div_next = '0;
        for (int i = 0; i < L; i++)
        begin
            half_num[i]        = {ph3_reg[i], 32'd0} + {32'd0, pl3_reg[i]};
            div_next.rem[i]    = half_num[i][95:32];
            div_next.nq[i]     = {half_num[i][31:0], 1'b0};
            div_next.mom[i]    = m3_reg[i];
        end
        div_next.nn      = nn3_reg;
        div_next.qneg    = qneg3_reg;
        div_next.density = den3_reg;
        div_next.energy  = egy3_reg;
        div_next.invalid = inv3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

// ===== design/slwg_div_step.sv =====
// One restoring-division step for all three lanes, registered.
// Uses slwg_pkg.
module slwg_div_step (
    input  logic           clk,
    input  logic           en,
    input  slwg_pkg::div_t d_in,
    output slwg_pkg::div_t d_out
);

    localparam int L  = slwg_pkg::LANES;
    localparam int QW = slwg_pkg::DIV_STEPS;

    logic [64:0]    trial [L];
    logic [64:0]    diff  [L];
    logic [L-1:0]   ge;
    slwg_pkg::div_t d_next;
    slwg_pkg::div_t d_reg;

    always_comb
    begin
        d_next = d_in;
        for (int i = 0; i < L; i++)
        begin
            trial[i] = {d_in.rem[i], d_in.nq[i][QW-1]};
            diff[i]  = trial[i] - {1'b0, d_in.nn};
            ge[i]    = trial[i] >= {1'b0, d_in.nn};
            d_next.rem[i] = ge[i] ? diff[i][63:0] : trial[i][63:0];
            d_next.nq[i]  = {d_in.nq[i][QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== design/slwg_round.sv =====
// Final stage: rounds the quotient, applies the correction, saturates and
// forms the ghost word. Combinational; uses slwg_pkg.
module slwg_round (
    input  slwg_pkg::div_t d_in,
    output slwg_pkg::out_t word
);

    localparam int L  = slwg_pkg::LANES;
    localparam int QW = slwg_pkg::DIV_STEPS;

    logic [QW:0]        q     [L];
    logic signed [35:0] corr  [L];
    logic signed [35:0] g     [L];
    logic [31:0]        sat   [L];

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            q[i]    = {1'b0, d_in.nq[i]}
                    + (QW+1)'({d_in.rem[i], 1'b0} >= {1'b0, d_in.nn});
            corr[i] = d_in.qneg[i] ? -$signed(36'(q[i])) : $signed(36'(q[i]));
            g[i]    = 36'($signed(d_in.mom[i])) - corr[i];
            if (d_in.invalid)
            begin
                sat[i] = 32'd0;
            end
            else if (g[i][35:31] == 5'b00000 || g[i][35:31] == 5'b11111)
            begin
                sat[i] = g[i][31:0];
            end
            else if (g[i][35])
            begin
                sat[i] = 32'h8000_0000;
            end
            else
            begin
                sat[i] = 32'h7FFF_FFFF;
            end
        end
        word.ghost_density = d_in.density;
        word.ghost_mom_x   = sat[0];
        word.ghost_mom_y   = sat[1];
        word.ghost_mom_z   = sat[2];
        word.ghost_energy  = d_in.energy;
        word.invalid       = d_in.invalid;
    end

endmodule

// ===== design/slip_wall_ghost_state.sv =====
// Slip-wall ghost state pipeline.
// Throughput one word per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// The depth is set by the 33-step restoring divider, one quotient bit a stage.
// rst_n (asynchronous, active low) clears all valid bits; data is not reset.
module slip_wall_ghost_state (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  slwg_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output slwg_pkg::out_t out_data
);

    // Four front stages and one stage per quotient bit carry valid bits here;
    // the output register holds the last valid bit.
    localparam int PIPE = slwg_pkg::FRONT_STAGES + slwg_pkg::DIV_STEPS;
    localparam int DS   = slwg_pkg::DIV_STEPS;

    logic            adv;
    logic [PIPE-1:0] v_reg;
    logic            out_valid_reg;
    slwg_pkg::out_t  out_reg;
    slwg_pkg::out_t  out_next;
    slwg_pkg::div_t  chain [DS+1];

    // Every stage moves when the output register is empty or being drained,
    // so a stall freezes all stages at once and nothing is lost or repeated.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[PIPE-2:0], in_valid};
            out_valid_reg <= v_reg[PIPE-1];
        end
    end

    // Products, dot product, |n|^2 and the scaled numerators.
    slwg_front u_front (
        .clk     (clk),
        .en      (adv),
        .in_data (in_data),
        .div_out (chain[0])
    );

    // The divider chain produces floor(2*|m.n|*|n_i| / |n|^2) per lane and
    // leaves the remainder for rounding.
    for (genvar k = 0; k < DS; k++)
    begin : g_div
        slwg_div_step u_step (
            .clk   (clk),
            .en    (adv),
            .d_in  (chain[k]),
            .d_out (chain[k+1])
        );
    end

    // Round half away from zero, reflect, saturate, and handle the invalid case.
    slwg_round u_round (
        .d_in (chain[DS]),
        .word (out_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== verif/tb_slip_wall_ghost_state.sv =====
// Self-checking testbench for the slip-wall ghost-state pipeline.
// Drives directed and random cell words, predicts each ghost word and compares.
// Depends on slwg_pkg and slip_wall_ghost_state.
`timescale 1ns / 1ps

module tb_slip_wall_ghost_state;

    localparam int N_RANDOM   = 1330;
    localparam int LATENCY    = 38;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    slwg_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    slwg_pkg::out_t out_data;

    slip_wall_ghost_state dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Ghost words still owed by the block, oldest first.
    slwg_pkg::out_t ghost_queue[$];
    int   errors = 0;
    int   n_in = 0;
    int   n_out = 0;
    int   n_invalid = 0;
    int   n_sat = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   no_idle = 1'b0;
    bit   hold_off = 1'b0;

    // Rounded magnitude of (num / den), ties away from zero.
    function automatic logic [127:0] round_div(input logic [127:0] num, input logic [127:0] den);
        logic [127:0] q;
        logic [127:0] r;
        begin
            q = num / den;
            r = num % den;
            if ((r << 1) >= den)
                q = q + 1;
            return q;
        end
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        begin
            if (v > 128'sd2147483647)
                return 32'sh7fffffff;
            if (v < -128'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        end
    endfunction

    // Mirror the momentum about the wall plane: g = m - 2(m.n)n/|n|^2.
    function automatic slwg_pkg::out_t reflect_cell(input slwg_pkg::in_t c);
        slwg_pkg::out_t g;
        logic signed [127:0] m[3];
        logic signed [127:0] n[3];
        logic signed [127:0] dot;
        logic signed [127:0] nn;
        logic signed [127:0] num;
        logic signed [127:0] corr;
        logic [127:0] q;
        begin
            m[0] = c.mom_x;    m[1] = c.mom_y;    m[2] = c.mom_z;
            n[0] = c.normal_x; n[1] = c.normal_y; n[2] = c.normal_z;
            dot = 0;
            nn = 0;
            for (int i = 0; i < 3; i++)
            begin
                dot += m[i] * n[i];
                nn += n[i] * n[i];
            end
            g = '0;
            g.ghost_density = c.density;
            g.ghost_energy = c.energy;
            if (nn == 0 || c.density <= 0)
            begin
                g.invalid = 1'b1;
                return g;
            end
            for (int i = 0; i < 3; i++)
            begin
                num = 2 * dot * n[i];
                q = round_div(num < 0 ? -num : num, nn);
                corr = num < 0 ? -$signed(q) : $signed(q);
                corr = m[i] - corr;
                if (i == 0) g.ghost_mom_x = clamp32(corr);
                if (i == 1) g.ghost_mom_y = clamp32(corr);
                if (i == 2) g.ghost_mom_z = clamp32(corr);
            end
            return g;
        end
    endfunction

    // Directed cells; the expected word is given only where it is obvious.
    typedef struct {
        slwg_pkg::in_t  word_in;
        bit             has_ghost;
        slwg_pkg::out_t ghost;
    } directed_row_t;

    localparam logic signed [31:0] ONE  = 32'sh00010000;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    directed_row_t rows[$];

    task automatic add_row(input slwg_pkg::in_t c, input bit known, input slwg_pkg::out_t g);
        directed_row_t r;
        begin
            r.word_in = c;
            r.has_ghost = known;
            r.ghost = g;
            rows.push_back(r);
        end
    endtask

    function automatic slwg_pkg::in_t mk(input logic signed [31:0] d, mx, my, mz, e, nx, ny, nz);
        slwg_pkg::in_t c;
        begin
            c.density = d;  c.mom_x = mx; c.mom_y = my; c.mom_z = mz;
            c.energy = e;   c.normal_x = nx; c.normal_y = ny; c.normal_z = nz;
            return c;
        end
    endfunction

    function automatic slwg_pkg::out_t mkg(input logic signed [31:0] d, mx, my, mz, e,
                                           input logic inv);
        slwg_pkg::out_t g;
        begin
            g.ghost_density = d; g.ghost_mom_x = mx; g.ghost_mom_y = my;
            g.ghost_mom_z = mz;  g.ghost_energy = e; g.invalid = inv;
            return g;
        end
    endfunction

    task automatic build_rows();
        begin
            // Zero normal: flagged, momenta zeroed, density and energy copied.
            add_row(mk(ONE, 5, 6, 7, 9, 0, 0, 0), 1, mkg(ONE, 0, 0, 0, 9, 1));
            // Zero and negative density are flagged even with a good normal.
            add_row(mk(0, 5, 6, 7, MAXV, ONE, 0, 0), 1, mkg(0, 0, 0, 0, MAXV, 1));
            add_row(mk(MINV, MAXV, MINV, 1, MINV, 0, ONE, 0), 1,
                    mkg(MINV, 0, 0, 0, MINV, 1));
            add_row(mk(-1, 1, 1, 1, -1, 0, 0, ONE), 1, mkg(-1, 0, 0, 0, -1, 1));
            // Axis normals flip exactly one component.
            add_row(mk(ONE, 100, 200, 300, 0, ONE, 0, 0), 1,
                    mkg(ONE, -100, 200, 300, 0, 0));
            add_row(mk(1, 100, 200, 300, 0, 0, -ONE, 0), 1,
                    mkg(1, 100, -200, 300, 0, 0));
            add_row(mk(MAXV, 100, 200, 300, MAXV, 0, 0, 3), 1,
                    mkg(MAXV, 100, 200, -300, MAXV, 0));
            // Flipping the most negative momentum saturates high; the most positive one flips to -MAXV.
            add_row(mk(ONE, MINV, 0, 0, 0, ONE, 0, 0), 1, mkg(ONE, MAXV, 0, 0, 0, 0));
            add_row(mk(ONE, MAXV, 0, 0, 0, MINV, 0, 0), 1, mkg(ONE, -MAXV, 0, 0, 0, 0));
            // Extremes and oblique normals, checked by the predictor.
            add_row(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0, '0);
            add_row(mk(1, MINV, MINV, MINV, MINV, MINV, MINV, MINV), 0, '0);
            add_row(mk(ONE, MAXV, MINV, MAXV, 0, MINV, MAXV, MINV), 0, '0);
            add_row(mk(ONE, 1, 1, 1, 0, 1, 1, 1), 0, '0);
            add_row(mk(ONE, 1, 0, 0, 0, 1, 1, 0), 0, '0);
            add_row(mk(ONE, 3, 0, 0, 0, 1, 1, 1), 0, '0);
            add_row(mk(ONE, -3, 0, 0, 0, 1, 1, 1), 0, '0);
            add_row(mk(ONE, MAXV, MAXV, 0, 0, 1, -1, 0), 0, '0);
            add_row(mk(ONE, 1, 2, 3, 4, 1, 0, 0), 0, '0);
            add_row(mk(ONE, -1, -2, -3, 4, 1, 1, 0), 0, '0);
        end
    endtask

    function automatic logic [31:0] rand_word(input int mode);
        begin
            case (mode)
                0: return $urandom;
                1: return $urandom_range(0, 255) - 128;
                2: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 16);
                default: return $urandom_range(0, 3) == 0 ? MINV : MAXV - $urandom_range(0, 2);
            endcase
        end
    endfunction

    // Mostly valid cells with a mix of magnitudes; some zero normals and bad densities.
    function automatic slwg_pkg::in_t rand_cell();
        slwg_pkg::in_t c;
        int  k;
        begin
            c.density  = rand_word($urandom_range(0, 3));
            if ($urandom_range(0, 9) != 0 && c.density <= 0)
                c.density = $urandom_range(1, 32'h7fffffff);
            c.mom_x    = rand_word($urandom_range(0, 3));
            c.mom_y    = rand_word($urandom_range(0, 3));
            c.mom_z    = rand_word($urandom_range(0, 3));
            c.energy   = $urandom;
            c.normal_x = rand_word($urandom_range(0, 3));
            c.normal_y = rand_word($urandom_range(0, 3));
            c.normal_z = rand_word($urandom_range(0, 3));
            k = $urandom_range(0, 19);
            if (k == 0)
            begin
                c.normal_x = 0; c.normal_y = 0; c.normal_z = 0;
            end
            else if (k < 5)
            begin
                // Axis-aligned walls, the common case on a structured grid.
                c.normal_y = 0;
                c.normal_z = 0;
            end
            return c;
        end
    endfunction

    // Offer one word and wait for the handshake; expectation queued on accept.
    // Valid stays high into the next word unless the sender idles first.
    task automatic send_cell(input slwg_pkg::in_t c, input bit known, input slwg_pkg::out_t g);
        slwg_pkg::out_t pred;
        begin
            while (!no_idle && $urandom_range(0, 99) < 33)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            pred = reflect_cell(c);
            if (known && pred !== g)
            begin
                $error("directed row disagrees with predictor");
                errors++;
            end
            in_valid <= 1'b1;
            in_data <= c;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            ghost_queue.push_back(known ? g : pred);
            if (pred.invalid) n_invalid++;
            n_in++;
            @(negedge clk);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off while the sender keeps going.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    // Result checker: compare each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_out++;
            if (ghost_queue.size() == 0)
            begin
                $error("unexpected output word %h", out_data);
                errors++;
            end
            else
            begin
                slwg_pkg::out_t e;
                e = ghost_queue.pop_front();
                if (out_data.ghost_density !== e.ghost_density)
                begin
                    $error("ghost_density exp %0d got %0d", e.ghost_density,
                           out_data.ghost_density);
                    errors++;
                end
                if (out_data.ghost_mom_x !== e.ghost_mom_x)
                begin
                    $error("ghost_mom_x exp %0d got %0d", e.ghost_mom_x, out_data.ghost_mom_x);
                    errors++;
                end
                if (out_data.ghost_mom_y !== e.ghost_mom_y)
                begin
                    $error("ghost_mom_y exp %0d got %0d", e.ghost_mom_y, out_data.ghost_mom_y);
                    errors++;
                end
                if (out_data.ghost_mom_z !== e.ghost_mom_z)
                begin
                    $error("ghost_mom_z exp %0d got %0d", e.ghost_mom_z, out_data.ghost_mom_z);
                    errors++;
                end
                if (out_data.ghost_energy !== e.ghost_energy)
                begin
                    $error("ghost_energy exp %0d got %0d", e.ghost_energy,
                           out_data.ghost_energy);
                    errors++;
                end
                if (out_data.invalid !== e.invalid)
                begin
                    $error("invalid exp %0b got %0b", e.invalid, out_data.invalid);
                    errors++;
                end
                if (!e.invalid && (e.ghost_mom_x == MAXV || e.ghost_mom_x == MINV))
                    n_sat++;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        build_rows();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table.
        foreach (rows[i])
            send_cell(rows[i].word_in, rows[i].has_ghost, rows[i].ghost);
        in_valid <= 1'b0;

        // Sender pause: let the pipeline drain completely.
        while (ghost_queue.size() != 0)
            @(negedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // A stretch of back-to-back words with no idling on either side.
            no_idle = (i >= 200 && i < 400);
            // Long receiver hold-off so the pipeline fills and stalls the input.
            if (i == 600)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (150) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            send_cell(rand_cell(), 0, '0);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;
        stim_done = 1'b1;

        while (ghost_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("Sent %0d cell words, checked %0d ghost words", n_in, n_out);
        $display("Flagged invalid: %0d, saturated x momentum: %0d", n_invalid, n_sat);
        if (errors == 0 && ghost_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/slwg_pkg.sv
design/slwg_front.sv
design/slwg_div_step.sv
design/slwg_round.sv
design/slip_wall_ghost_state.sv
verif/tb_slip_wall_ghost_state.sv
